/* sv/sm3_pkg.sv */
// sm3 shared constants, types and round functions
`default_nettype none
package sm3_pkg;
  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] IV [8] = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                     32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       we;
    logic [3:0] waddr;
    word_t      wdata;
    logic [3:0] raddr;
  } wmem_req_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t p0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage
`default_nettype wire

/* sv/sm3_wmem.sv */
// sm3 sixteen-entry message word memory, one write and one registered read
`default_nettype none
module sm3_wmem
  import sm3_pkg::*;
(
  input  wire logic      clk,
  input  wire wmem_req_t req,
  output word_t          rdata
);
  word_t mem [16];
  word_t rdata_r;
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata_r <= mem[req.raddr];
  end
  assign rdata = rdata_r;
endmodule
`default_nettype wire

/* sv/sm3_hash_engine_top.sv */
// sm3 hash engine top level: word packing, padding and a one-round-per-cycle compressor
// a word that fills a block stalls input while the window loads and the compressor runs its rounds
// throughput: one word per cycle inside a block; input then stalls until that block is compressed
// a last word writes one padding word per cycle, one or two compressions, eight digest transfers
// synchronous active-low reset loads the initial vector and clears the length and counters
`default_nettype none
module sm3_hash_engine_top
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // message_word[31:0], valid_bytes[34:32], zeros
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // digest_word[31:0]
  output logic             out_tlast
);
  localparam logic [2:0] S_IN = 3'd0, S_PAD = 3'd1, S_LOAD = 3'd2, S_RUN = 3'd3,
                         S_OUT = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;     // message end seen, padding in progress
  logic        pend_r, pend_nxt;   // pad word still to be written
  logic        skip_r, skip_nxt;   // no room for the length in this block
  logic        lst_r, lst_nxt;     // length written, final block queued
  logic [2:0]  oidx_r, oidx_nxt;
  word_t       cv_r [8];
  word_t       wr_r [8];
  word_t       win_r [16];         // sliding window of expanded words
  wmem_req_t   req;
  word_t       rdata;
  word_t       in_word;
  logic [2:0]  nb;
  logic        acc, out_acc, run_end, out_end;
  word_t       short_pad, pad_word;
  logic [5:0]  j;
  word_t       wj, w4, a, b, c, d, e, f, g, h, ff, gg, a12, ss1, ss2, tt1, tt2, tj, wnew;
  logic        wr_word;
  word_t       wr_data;

  sm3_wmem u_wmem (.clk(clk), .req(req), .rdata(rdata));

  assign in_word = in_tdata[31:0];
  assign nb = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];
  assign acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (st_r == S_IN);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = cv_r[oidx_r];
  assign out_tlast = (oidx_r == 3'd7);
  assign run_end = (st_r == S_RUN) && (rnd_r == 6'd63);
  assign out_end = (st_r == S_OUT) && out_acc && (oidx_r == 3'd7);

  // padding word derived from a short final word
  always_comb begin
    case (nb)
      3'd0: short_pad = 32'h80000000;
      3'd1: short_pad = {in_word[31:24], PAD_BYTE, 16'h0};
      3'd2: short_pad = {in_word[31:16], PAD_BYTE, 8'h0};
      default: short_pad = {in_word[31:8], PAD_BYTE};
    endcase
  end

  // padding stream word for current position
  always_comb begin
    if (pend_r) pad_word = {PAD_BYTE, 24'h0};
    else if (skip_r) pad_word = '0;
    else if (pos_r == 4'd14) pad_word = len_r[63:32];
    else if (pos_r == 4'd15) pad_word = len_r[31:0];
    else pad_word = '0;
  end

  // round datapath
  assign j = rnd_r;
  assign wj = win_r[0];
  assign w4 = win_r[4];
  assign wnew = p1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 5'd15)) ^ rotl(win_r[3], 5'd7)
                ^ win_r[10];
  always_comb begin
    a = wr_r[0]; b = wr_r[1]; c = wr_r[2]; d = wr_r[3];
    e = wr_r[4]; f = wr_r[5]; g = wr_r[6]; h = wr_r[7];
    if (j < 6'd16) begin
      tj = T_LOW; ff = a ^ b ^ c; gg = e ^ f ^ g;
    end else begin
      tj = T_HIGH; ff = (a & b) | (a & c) | (b & c); gg = (e & f) | (~e & g);
    end
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tj, j[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    tt1 = ff + d + ss2 + (wj ^ w4);
    tt2 = gg + h + ss1 + wj;
  end

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; len_nxt = len_r; rnd_nxt = rnd_r;
    fin_nxt = fin_r; pend_nxt = pend_r; skip_nxt = skip_r; lst_nxt = lst_r;
    oidx_nxt = oidx_r;
    wr_word = 1'b0; wr_data = '0;
    case (st_r)
      S_IN: begin
        if (acc) begin
          wr_word = 1'b1;
          if (!in_tlast) begin
            wr_data = in_word; len_nxt = len_r + 64'd32;
          end else begin
            len_nxt = len_r + {58'd0, nb, 3'd0};
            fin_nxt = 1'b1;
            st_nxt = S_PAD;
            if (nb == 3'd4) begin
              wr_data = in_word; pend_nxt = 1'b1;
            end else begin
              wr_data = short_pad; skip_nxt = (pos_r == 4'd14);
            end
          end
        end
      end
      S_PAD: begin
        wr_word = 1'b1; wr_data = pad_word;
        if (pend_r) begin
          pend_nxt = 1'b0; skip_nxt = (pos_r == 4'd14);
        end else if (skip_r) begin
          if (pos_r == 4'd15) skip_nxt = 1'b0;
        end else if (pos_r == 4'd15) begin
          lst_nxt = 1'b1;
        end
      end
      S_LOAD: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd16) begin
          st_nxt = S_RUN; rnd_nxt = '0;
        end
      end
      S_RUN: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) st_nxt = lst_r ? S_OUT : (fin_r ? S_PAD : S_IN);
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            st_nxt = S_IN; fin_nxt = 1'b0; lst_nxt = 1'b0; len_nxt = '0;
          end
        end
      end
      default: st_nxt = S_IN;
    endcase
    if (wr_word) begin
      pos_nxt = pos_r + 4'd1;
      if (pos_r == 4'd15) st_nxt = S_LOAD;
    end
  end

  // memory requests: write the current word at its position, and fetch words 0..15 into the window during load
  always_comb begin
    req.we = wr_word; req.waddr = pos_r; req.wdata = wr_data;
    req.raddr = rnd_r[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IN; pos_r <= '0; len_r <= '0; rnd_r <= '0;
      fin_r <= 1'b0; pend_r <= 1'b0; skip_r <= 1'b0; lst_r <= 1'b0; oidx_r <= '0;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
    end else begin
      st_r <= st_nxt; pos_r <= pos_nxt; len_r <= len_nxt; rnd_r <= rnd_nxt;
      fin_r <= fin_nxt; pend_r <= pend_nxt; skip_r <= skip_nxt; lst_r <= lst_nxt;
      oidx_r <= oidx_nxt;
      if (run_end) begin
        cv_r[0] <= cv_r[0] ^ tt1;
        cv_r[1] <= cv_r[1] ^ a;
        cv_r[2] <= cv_r[2] ^ rotl(b, 5'd9);
        cv_r[3] <= cv_r[3] ^ c;
        cv_r[4] <= cv_r[4] ^ p0(tt2);
        cv_r[5] <= cv_r[5] ^ e;
        cv_r[6] <= cv_r[6] ^ rotl(f, 5'd19);
        cv_r[7] <= cv_r[7] ^ g;
      end else if (out_end) begin
        for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_LOAD) begin
      if (rnd_r != 6'd0) begin
        for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
        win_r[15] <= rdata;
      end
      for (int i = 0; i < 8; i++) wr_r[i] <= cv_r[i];
    end else if (st_r == S_RUN) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= wnew;
      wr_r[0] <= tt1; wr_r[1] <= a; wr_r[2] <= rotl(b, 5'd9); wr_r[3] <= c;
      wr_r[4] <= p0(tt2); wr_r[5] <= e; wr_r[6] <= rotl(f, 5'd19); wr_r[7] <= g;
    end
  end
endmodule
`default_nettype wire

/* sv/sm3_hash_engine_chk.sv */
// sm3 port checker and its bind
`default_nettype none
module sm3_hash_engine_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input open while digest pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("digest transfer dropped");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
endmodule

bind sm3_hash_engine_top sm3_hash_engine_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire
